// File: sv/keyed_record_table_assert.svh
// Assertion shorthands for the checker file.
`ifndef KEYED_RECORD_TABLE_ASSERT_SVH
`define KEYED_RECORD_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, quiet during reset.
`define KRT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keyed_record_table: check failed");

// Next-cycle implication, sampled on i_clk, quiet during reset.
`define KRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keyed_record_table: check failed");

`endif

// File: sv/krt_pkg.sv
package krt_pkg;

    localparam int KEY_W        = 32;
    localparam int PRICE_W      = 24;
    localparam int QTY_W        = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 7;
    localparam int TABLE_ENTRIES_DEF = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_ADJUST = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // One stored record
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PRICE_W-1:0]      price;
        logic signed [QTY_W-1:0] qty;
    } t_record;

endpackage

// File: sv/krt_store.sv
module krt_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  krt_pkg::t_record  i_wr_data,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output krt_pkg::t_record  o_rd_data
);
    import krt_pkg::*;

    t_record r_mem [DEPTH];
    t_record r_rd_data;

    // Write one record per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one record per cycle; hold the data while the read is idle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/krt_alu.sv
module krt_alu (
    input  logic signed [krt_pkg::KEY_W-1:0] i_stored_key,
    input  logic signed [krt_pkg::KEY_W-1:0] i_search_key,
    input  logic signed [krt_pkg::QTY_W-1:0] i_stored_qty,
    input  logic signed [krt_pkg::QTY_W-1:0] i_delta,
    output logic                             o_match,
    output logic signed [krt_pkg::QTY_W-1:0] o_sum
);
    import krt_pkg::*;

    logic signed [QTY_W:0] sum_wide;

    // Compare the stored key against the one searched for
    assign o_match = (i_stored_key == i_search_key);

    // Add the change with one guard bit, then clamp on overflow
    assign sum_wide = {i_stored_qty[QTY_W-1], i_stored_qty} + {i_delta[QTY_W-1], i_delta};

    always_comb begin
        if (sum_wide[QTY_W] != sum_wide[QTY_W-1]) begin
            o_sum = sum_wide[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
        end else begin
            o_sum = sum_wide[QTY_W-1:0];
        end
    end

endmodule

// File: sv/keyed_record_table.sv
// Keyed record table. Holds up to TABLE_ENTRIES records (key, price, quantity)
// in one single-port-read record memory and finds keys by scanning the held
// records in insertion order, one key compare per clock. An operation is
// transferred when start is high and busy is low; busy stays high until the
// result. An insert into an empty or full table and the unused opcode skip the
// scan. The scan rate is set by the memory read port, one record per cycle.
// The result shows on the o_ ports for exactly one cycle, marked by
// o_result_valid, and cannot be held off; a new operation may be transferred
// in that same cycle. No memory clearing is done after reset: only written
// records are ever read.
module keyed_record_table #(
    parameter int TABLE_ENTRIES = krt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [krt_pkg::OP_W-1:0]             i_operation,
    input  logic signed [krt_pkg::KEY_W-1:0]     i_part_key,
    input  logic [krt_pkg::PRICE_W-1:0]          i_price_cents,
    input  logic signed [krt_pkg::QTY_W-1:0]     i_quantity_value,
    output logic                                 o_result_valid,
    output logic [krt_pkg::STATUS_W-1:0]         o_status,
    output logic [krt_pkg::PRICE_W-1:0]          o_found_price,
    output logic signed [krt_pkg::QTY_W-1:0]     o_found_quantity,
    output logic [krt_pkg::COUNT_OUT_W-1:0]      o_entry_count
);
    import krt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_HIT   = 5'b00100,
        S_WRITE = 5'b01000,
        S_REPLY = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic r_cmp_vld, n_cmp_vld;
    logic r_result_valid, n_result_valid;

    // Captured operation
    logic [OP_W-1:0]          r_op;
    logic signed [KEY_W-1:0]  r_key;
    logic [PRICE_W-1:0]       r_price;
    logic signed [QTY_W-1:0]  r_qval;
    logic [STATUS_W-1:0]      r_stat, n_stat;

    // Result payload
    logic [STATUS_W-1:0]      r_status, n_status;
    logic [PRICE_W-1:0]       r_out_price, n_out_price;
    logic signed [QTY_W-1:0]  r_out_qty, n_out_qty;
    logic [COUNT_OUT_W-1:0]   r_out_cnt, n_out_cnt;

    // Memory and unit wiring
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    t_record                  wr_data;
    logic                     rd_en;
    t_record                  rd_data;
    logic                     key_match;
    logic signed [QTY_W-1:0]  qty_sum;
    logic                     accept;
    logic                     table_full;
    logic                     last_cmp;

    krt_store #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    krt_alu u_alu (
        .i_stored_key (rd_data.key),
        .i_search_key (r_key),
        .i_stored_qty (rd_data.qty),
        .i_delta      (r_qval),
        .o_match      (key_match),
        .o_sum        (qty_sum)
    );

    assign accept     = start && (r_state == S_IDLE);
    assign table_full = (r_count == CNT_W'(TABLE_ENTRIES));
    assign last_cmp   = ((r_cmp_idx + CNT_W'(1)) == r_count);

    // Sequencer: scan, then finish with a hit, an append or a plain reply
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_idx          = r_idx;
        n_cmp_idx      = r_cmp_idx;
        n_cmp_vld      = 1'b0;
        n_stat         = r_stat;
        n_result_valid = 1'b0;
        n_status       = r_status;
        n_out_price    = r_out_price;
        n_out_qty      = r_out_qty;
        n_out_cnt      = r_out_cnt;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = r_count[IDX_W-1:0];
        wr_data        = '{key: r_key, price: r_price, qty: r_qval};

        unique case (r_state)
            S_IDLE: begin
                n_idx  = '0;
                n_stat = ST_DONE;
                if (accept) begin
                    case (i_operation)
                        OP_INSERT: begin
                            if (table_full) begin
                                n_stat  = ST_FULL;
                                n_state = S_REPLY;
                            end else if (r_count == '0) begin
                                n_state = S_WRITE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_LOOKUP, OP_ADJUST: begin
                            if (r_count == '0) begin
                                n_stat  = ST_NOT_FOUND;
                                n_state = S_REPLY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_REPLY;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Issue the next read unless the record now compared matches
                rd_en = (r_idx < r_count) && !(r_cmp_vld && key_match);
                if (rd_en) begin
                    n_idx     = r_idx + CNT_W'(1);
                    n_cmp_idx = r_idx;
                end
                n_cmp_vld = rd_en;
                if (r_cmp_vld && key_match) begin
                    if (r_op == OP_INSERT) begin
                        n_stat  = ST_DUPLICATE;
                        n_state = S_REPLY;
                    end else begin
                        n_state = S_HIT;
                    end
                end else if (r_cmp_vld && last_cmp) begin
                    if (r_op == OP_INSERT) begin
                        n_state = S_WRITE;
                    end else begin
                        n_stat  = ST_NOT_FOUND;
                        n_state = S_REPLY;
                    end
                end
            end
            S_HIT: begin
                // Read data still holds the matching record
                n_status    = ST_DONE;
                n_out_price = rd_data.price;
                if (r_op == OP_ADJUST) begin
                    wr_en     = 1'b1;
                    wr_addr   = r_cmp_idx[IDX_W-1:0];
                    wr_data   = '{key: rd_data.key, price: rd_data.price, qty: qty_sum};
                    n_out_qty = qty_sum;
                end else begin
                    n_out_qty = rd_data.qty;
                end
                n_out_cnt      = COUNT_OUT_W'(r_count);
                n_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            S_WRITE: begin
                // Append the new record at the end of the table
                wr_en          = 1'b1;
                n_count        = r_count + CNT_W'(1);
                n_status       = ST_DONE;
                n_out_price    = '0;
                n_out_qty      = '0;
                n_out_cnt      = COUNT_OUT_W'(r_count + CNT_W'(1));
                n_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            S_REPLY: begin
                n_status       = r_stat;
                n_out_price    = '0;
                n_out_qty      = '0;
                n_out_cnt      = COUNT_OUT_W'(r_count);
                n_result_valid = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_idx          <= '0;
            r_cmp_vld      <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_idx          <= n_idx;
            r_cmp_vld      <= n_cmp_vld;
            r_result_valid <= n_result_valid;
        end
    end

    // Payload: capture the operation on transfer, hold results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_operation;
            r_key   <= i_part_key;
            r_price <= i_price_cents;
            r_qval  <= i_quantity_value;
        end
        r_stat      <= n_stat;
        r_cmp_idx   <= n_cmp_idx;
        r_status    <= n_status;
        r_out_price <= n_out_price;
        r_out_qty   <= n_out_qty;
        r_out_cnt   <= n_out_cnt;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_result_valid   = r_result_valid;
    assign o_status         = r_status;
    assign o_found_price    = r_out_price;
    assign o_found_quantity = r_out_qty;
    assign o_entry_count    = r_out_cnt;

endmodule

// File: sv/krt_checker.sv
`include "keyed_record_table_assert.svh"

module krt_checker #(
    parameter int TABLE_ENTRIES = krt_pkg::TABLE_ENTRIES_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_result_valid,
    input logic [krt_pkg::STATUS_W-1:0]      o_status,
    input logic [krt_pkg::PRICE_W-1:0]       o_found_price,
    input logic [krt_pkg::QTY_W-1:0]         o_found_quantity,
    input logic [krt_pkg::COUNT_OUT_W-1:0]   o_entry_count
);
    import krt_pkg::*;

    // A transferred operation keeps the block busy in the next cycle
    `KRT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)

    // A result arrives only as the block goes idle
    `KRT_ASSERT_IMPL(a_result_when_idle, o_result_valid, !busy)

    // Rejected operations (any status other than done) report no record
    `KRT_ASSERT_IMPL(a_zero_on_reject, o_result_valid && o_status != ST_DONE, o_found_price == '0 && o_found_quantity == '0)

    // A full-table reject reports the full count
    `KRT_ASSERT_IMPL(a_full_count, o_result_valid && o_status == ST_FULL, o_entry_count == COUNT_OUT_W'(TABLE_ENTRIES))

endmodule

bind keyed_record_table krt_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_krt_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import krt_pkg::*;

    localparam int TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
    localparam int RANDOM_ITEMS   = 1630;
    localparam int TAIL_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    // Opcode 3 is not defined in the package; the block must ignore it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [QTY_W-1:0] QTY_MIN   = 32'sh8000_0000;
    localparam logic signed [QTY_W-1:0] QTY_MAX   = 32'sh7fff_ffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX   = 32'sh7fff_ffff;
    localparam logic [PRICE_W-1:0]      PRICE_MAX = '1;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [PRICE_W-1:0]      price;
        logic signed [QTY_W-1:0] qty;
        logic [COUNT_OUT_W-1:0]  count;
    } t_table_result;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
        logic [PRICE_W-1:0]      price;
        logic signed [QTY_W-1:0] qty;
        logic                    typed;
        t_table_result           want;
    } t_op_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [OP_W-1:0]             i_operation;
    logic signed [KEY_W-1:0]     i_part_key;
    logic [PRICE_W-1:0]          i_price_cents;
    logic signed [QTY_W-1:0]     i_quantity_value;
    logic                        o_result_valid;
    logic [STATUS_W-1:0]         o_status;
    logic [PRICE_W-1:0]          o_found_price;
    logic signed [QTY_W-1:0]     o_found_quantity;
    logic [COUNT_OUT_W-1:0]      o_entry_count;

    // Shadow copy of the table contents
    logic signed [KEY_W-1:0]     model_key   [TABLE_ENTRIES];
    logic [PRICE_W-1:0]          model_price [TABLE_ENTRIES];
    logic signed [QTY_W-1:0]     model_qty   [TABLE_ENTRIES];
    int                          model_count;

    t_table_result               pending_results[$];
    t_op_row                     directed_rows[$];
    logic                        row_typed;
    t_table_result               row_expect;

    int                          err_count;
    int                          sent_count;
    int                          idle_count;
    int                          status_seen[4];
    int                          saturations;

    keyed_record_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (i_operation),
        .i_part_key       (i_part_key),
        .i_price_cents    (i_price_cents),
        .i_quantity_value (i_quantity_value),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_found_price    (o_found_price),
        .o_found_quantity (o_found_quantity),
        .o_entry_count    (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Apply one table operation to the shadow table and return its result
    function automatic t_table_result predict_table_op(
        logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key,
        logic [PRICE_W-1:0] price, logic signed [QTY_W-1:0] qty);
        t_table_result r;
        int            hit;
        int            i;
        longint        sum;
        r = '0;
        r.status = ST_DONE;
        hit = -1;
        for (i = 0; i < model_count; i++) begin
            if (hit < 0 && model_key[i] == key) hit = i;
        end
        case (op)
            OP_INSERT: begin
                // Capacity is checked before the duplicate key
                if (model_count >= TABLE_ENTRIES) begin
                    r.status = ST_FULL;
                end else if (hit >= 0) begin
                    r.status = ST_DUPLICATE;
                end else begin
                    model_key[model_count]   = key;
                    model_price[model_count] = price;
                    model_qty[model_count]   = qty;
                    model_count++;
                end
            end
            OP_LOOKUP, OP_ADJUST: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    if (op == OP_ADJUST) begin
                        // Saturate the quantity at the signed 32-bit limits
                        sum = longint'(model_qty[hit]) + longint'(qty);
                        if (sum > longint'(QTY_MAX)) begin
                            sum = longint'(QTY_MAX);
                            saturations++;
                        end
                        if (sum < longint'(QTY_MIN)) begin
                            sum = longint'(QTY_MIN);
                            saturations++;
                        end
                        model_qty[hit] = sum[QTY_W-1:0];
                    end
                    r.price = model_price[hit];
                    r.qty   = model_qty[hit];
                end
            end
            default: ;
        endcase
        r.count = model_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    // Boundary words for keys and quantities
    function automatic logic [31:0] corner_word(int sel);
        case (sel)
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            4:       return 32'h0000_0001;
            default: return 32'h8000_0001;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    task automatic add_row(logic [OP_W-1:0] op, logic [31:0] key, logic [PRICE_W-1:0] price,
                           logic [31:0] qty, logic typed, logic [STATUS_W-1:0] st,
                           logic [PRICE_W-1:0] fp, logic [31:0] fq, int cnt);
        t_op_row row;
        row.op          = op;
        row.key         = key;
        row.price       = price;
        row.qty         = qty;
        row.typed       = typed;
        row.want.status = st;
        row.want.price  = fp;
        row.want.qty    = fq;
        row.want.count  = cnt[COUNT_OUT_W-1:0];
        directed_rows.push_back(row);
    endtask

    // Present one operation and hold it until the block takes the transfer
    task automatic send_op(t_op_row row);
        @(negedge i_clk);
        start            <= 1'b1;
        i_operation      <= row.op;
        i_part_key       <= row.key;
        i_price_cents    <= row.price;
        i_quantity_value <= row.qty;
        row_typed        <= row.typed;
        row_expect       <= row.want;
        do @(posedge i_clk); while (!(start === 1'b1 && busy === 1'b0));
    endtask

    // Drop start for a number of cycles, with noise on the payload
    task automatic idle_for(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start            <= 1'b0;
            i_operation      <= OP_W'($urandom);
            i_part_key       <= $urandom;
            i_price_cents    <= PRICE_W'($urandom);
            i_quantity_value <= $urandom;
        end
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain();
        idle_for(1);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Check each result against the oldest expectation, then record new transfers
    always @(posedge i_clk) begin : result_check
        t_table_result got;
        t_table_result want;
        t_table_result model;
        logic          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_result_valid === 1'b1) begin
                moved      = 1'b1;
                got.status = o_status;
                got.price  = o_found_price;
                got.qty    = o_found_quantity;
                got.count  = o_entry_count;
                if (!$isunknown(o_status)) status_seen[o_status]++;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0h", $time, o_status);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("found_price", 32'(want.price), 32'(got.price));
                    check_field("found_quantity", want.qty, got.qty);
                    check_field("entry_count", 32'(want.count), 32'(got.count));
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                moved = 1'b1;
                model = predict_table_op(i_operation, i_part_key, i_price_cents,
                                         i_quantity_value);
                pending_results.push_back(row_typed ? row_expect : model);
                sent_count++;
            end
        end
        idle_count = moved ? 0 : idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_op_row row;
        int      random_sent;
        int      burst;
        int      j;
        int      pick;
        logic    full;

        err_count        = 0;
        sent_count       = 0;
        idle_count       = 0;
        saturations      = 0;
        model_count      = 0;
        status_seen      = '{0, 0, 0, 0};
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_operation      = '0;
        i_part_key       = '0;
        i_price_cents    = '0;
        i_quantity_value = '0;
        row_typed        = 1'b0;
        row_expect       = '0;

        // Empty table, boundary keys and quantities, saturation both ways
        add_row(OP_LOOKUP, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(OP_ADJUST, -1, 5, 7, 1, ST_NOT_FOUND, 0, 0, 0);
        add_row(OP_UNUSED, 0, 0, 0, 1, ST_DONE, 0, 0, 0);
        add_row(OP_INSERT, KEY_MIN, PRICE_MAX, QTY_MAX, 1, ST_DONE, 0, 0, 1);
        add_row(OP_INSERT, KEY_MAX, 0, QTY_MIN, 1, ST_DONE, 0, 0, 2);
        add_row(OP_INSERT, KEY_MIN, 100, 3, 1, ST_DUPLICATE, 0, 0, 2);
        add_row(OP_LOOKUP, KEY_MIN, 0, 0, 1, ST_DONE, PRICE_MAX, QTY_MAX, 2);
        add_row(OP_LOOKUP, KEY_MAX, 0, 0, 1, ST_DONE, 0, QTY_MIN, 2);
        add_row(OP_ADJUST, KEY_MIN, 0, 1, 1, ST_DONE, PRICE_MAX, QTY_MAX, 2);
        add_row(OP_ADJUST, KEY_MAX, 0, -1, 1, ST_DONE, 0, QTY_MIN, 2);
        add_row(OP_ADJUST, KEY_MIN, 0, QTY_MIN, 0, ST_DONE, 0, 0, 0);
        add_row(OP_ADJUST, KEY_MAX, 0, QTY_MAX, 0, ST_DONE, 0, 0, 0);
        add_row(OP_INSERT, 0, 12345, 0, 1, ST_DONE, 0, 0, 3);
        add_row(OP_ADJUST, 0, 0, QTY_MIN, 0, ST_DONE, 0, 0, 0);
        add_row(OP_ADJUST, 0, 0, QTY_MIN, 0, ST_DONE, 0, 0, 0);
        add_row(OP_LOOKUP, 1, 0, 0, 1, ST_NOT_FOUND, 0, 0, 3);
        add_row(OP_UNUSED, KEY_MAX, PRICE_MAX, QTY_MAX, 1, ST_DONE, 0, 0, 3);
        add_row(OP_INSERT, -1, 1, -1, 1, ST_DONE, 0, 0, 4);
        add_row(OP_ADJUST, -1, 0, QTY_MAX, 0, ST_DONE, 0, 0, 0);
        add_row(OP_ADJUST, -1, 0, QTY_MAX, 0, ST_DONE, 0, 0, 0);
        add_row(OP_LOOKUP, -1, PRICE_MAX, QTY_MIN, 0, ST_DONE, 0, 0, 0);

        // Hold reset low, then release it on a falling edge
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table back to back
        foreach (directed_rows[k]) send_op(directed_rows[k]);

        // Random bursts; the table fills once and then stays full
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (j = 0; j < burst && random_sent < RANDOM_ITEMS; j++) begin
                full = (model_count >= TABLE_ENTRIES);
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    row.op = OP_UNUSED;
                else if (pick < (full ? 20 : 35))
                    row.op = OP_INSERT;
                else if (pick < (full ? 60 : 68))
                    row.op = OP_LOOKUP;
                else
                    row.op = OP_ADJUST;

                // Mostly held keys so lookups and adjusts hit, some duplicates
                pick = $urandom_range(0, 99);
                if (model_count > 0 && pick < (row.op == OP_INSERT ? 25 : 70))
                    row.key = model_key[$urandom_range(0, model_count - 1)];
                else if (pick < 85)
                    row.key = $urandom;
                else
                    row.key = corner_word($urandom_range(0, 5));

                pick = $urandom_range(0, 9);
                row.price = (pick == 0) ? '0 : (pick == 1) ? PRICE_MAX : PRICE_W'($urandom);

                pick = $urandom_range(0, 9);
                if (pick < 4)
                    row.qty = $signed($urandom_range(0, 2000)) - 1000;
                else if (pick < 7)
                    row.qty = $urandom;
                else
                    row.qty = corner_word($urandom_range(0, 5));

                row.typed = 1'b0;
                row.want  = '0;
                send_op(row);
                random_sent++;
                if (random_sent == RANDOM_ITEMS / 2) drain();
            end
            if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 40));
        end

        // Let the last results arrive, then watch for strays
        drain();
        idle_for(TAIL_CYCLES);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            err_count++;
        end

        $display("Sent %0d table operations; results done %0d, not found %0d,",
                 sent_count, status_seen[ST_DONE], status_seen[ST_NOT_FOUND]);
        $display("duplicate %0d, full %0d; quantity saturated %0d times; %0d records at end",
                 status_seen[ST_DUPLICATE], status_seen[ST_FULL], saturations, model_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
